@@ src/ball_membership_clusterer_macros.svh @@
// assertion macros for the ball membership clusterer
// no dependencies; included by ball_membership_clusterer.sv, which carries the assertions
`ifndef BALL_MEMBERSHIP_CLUSTERER_MACROS_SVH
`define BALL_MEMBERSHIP_CLUSTERER_MACROS_SVH

// same-cycle implication
`define BMC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BMC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bmc_pkg.sv @@
// types and constants of the ball membership clusterer
// no dependencies
package bmc_pkg;

  localparam int MAX_BALLS   = 64;
  localparam int MAX_MEMBERS = 256;
  localparam int COORD_BITS  = 32;

  localparam int BALL_AW = $clog2(MAX_BALLS);
  localparam int MEMB_AW = $clog2(MAX_MEMBERS);
  localparam int STORE_AW = BALL_AW + MEMB_AW;
  localparam int CNT_W = 9;
  localparam int P_W = 20;
  localparam int RAD_W = 31;
  localparam int ID_W = 31;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [P_W-1:0] P_MAX = {P_W{1'b1}};
  localparam logic [CNT_W-1:0] MEMB_LIMIT = CNT_W'(MAX_MEMBERS);

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_OBJECT = 2'd1,
    KIND_READ   = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EPS      = 8'd0,
    REG_MIN_SIZE = 8'd1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic signed [31:0]     pos_x;
    logic signed [31:0]     pos_y;
    logic signed [31:0]     pos_z;
    logic [RAD_W-1:0]       ball_radius;
    logic [ID_W-1:0]        object_id;
    logic                   object_interior;
    logic                   is_p_label;
    logic [5:0]             ball_slot;
    logic [7:0]             member_slot;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  member_id;
    logic             entry_valid;
    logic [CNT_W-1:0] members_stored;
    logic [P_W-1:0]   p_total;
    logic             qualifies;
    logic             all_interior;
    logic [RAD_W-1:0] effective_radius;
    logic             list_overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic [RAD_W-1:0]             r;
  } geo_t;

  typedef struct packed {
    logic [P_W-1:0]   p_count;
    logic [CNT_W-1:0] count;
    logic             interior;
    logic             overflow;
  } summ_t;

  localparam summ_t SUMM_RESET = '{p_count: '0, count: '0, interior: 1'b1, overflow: 1'b0};

  // one ball slot: geometry and running summary
  typedef struct packed {
    geo_t  geo;
    summ_t summ;
  } ball_t;

endpackage

@@ src/bmc_ifs.sv @@
// handshake channels of the ball membership clusterer
// depends on bmc_pkg
interface bmc_in_if;
  logic valid;
  logic ready;
  bmc_pkg::in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bmc_out_if;
  logic valid;
  logic ready;
  bmc_pkg::out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

interface bmc_cfg_if;
  logic valid;
  logic ready;
  logic [bmc_pkg::CFG_IDX_W-1:0] index;
  logic [bmc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ src/ball_membership_clusterer.sv @@
// Object items scan all 64 ball slots through a pipeline fed one ball per
// cycle from the ball memory, with a drain after the scan.
// Load and clear items need no scan; a read item's result is registered from the
// memory outputs, and the next item is taken while a result waits.
// Reset (rst, synchronous) clears loaded flags, registers and control; the
// memories keep their contents and need no clearing pass.
`include "ball_membership_clusterer_macros.svh"

module ball_membership_clusterer (
  input logic clk,
  input logic rst,
  bmc_cfg_if.sink cfg,
  bmc_in_if.sink items,
  bmc_out_if.source results
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_RDOUT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [bmc_pkg::RAD_W-1:0] eps;
  logic [bmc_pkg::P_W-1:0] min_size;
  logic [bmc_pkg::MAX_BALLS-1:0] ball_loaded;

  // object held for the scan
  logic signed [31:0] obj_x, obj_y, obj_z;
  logic [bmc_pkg::ID_W-1:0] obj_id;
  logic obj_interior, obj_p;

  // memories
  bmc_pkg::ball_t ball_mem [bmc_pkg::MAX_BALLS];
  logic [bmc_pkg::ID_W-1:0] store_mem [2**bmc_pkg::STORE_AW];

  bmc_pkg::ball_t ball_q, ball_wd;
  logic [bmc_pkg::ID_W-1:0] store_q;
  logic ball_we, ball_geo_we, ball_re, store_we, store_re;
  logic [bmc_pkg::BALL_AW-1:0] ball_wa, ball_ra;
  logic [bmc_pkg::STORE_AW-1:0] store_wa, store_ra;

  // geometry is written only by a load, the summary also by a hit
  always_ff @(posedge clk) begin
    if (ball_we) begin
      if (ball_geo_we) ball_mem[ball_wa].geo <= ball_wd.geo;
      ball_mem[ball_wa].summ <= ball_wd.summ;
    end
    if (ball_re) ball_q <= ball_mem[ball_ra];
  end

  always_ff @(posedge clk) begin
    if (store_we) store_mem[store_wa] <= obj_id;
    if (store_re) store_q <= store_mem[store_ra];
  end

  // read item held until its result is registered
  logic rd_loaded, rd_pending;
  logic [7:0] rd_mslot;

  logic accept;
  assign items.ready = (state == ST_IDLE);
  assign accept = items.valid && items.ready;
  assign cfg.ready = 1'b1;

  // scan pipeline
  logic [bmc_pkg::BALL_AW-1:0] scan_idx, idx1, idx2, idx3, idx4;
  logic v1, v2, v3, v4, ld1;
  logic [32:0] dx2, dy2, dz2;
  logic [bmc_pkg::RAD_W-1:0] r2;
  logic [61:0] sqx3, sqy3, sqz3, rr3;
  logic near3;
  bmc_pkg::summ_t summ2, summ3, summ4;

  function automatic logic [32:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    return d[32] ? 33'(-d) : 33'(d);
  endfunction

  logic hit3;
  logic [63:0] sum3;
  assign sum3 = 64'(sqx3) + 64'(sqy3) + 64'(sqz3);
  assign hit3 = v3 && near3 && (sum3 < 64'(rr3));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= (state == ST_SCAN);
      v2 <= v1 && ld1;
      v3 <= v2;
      v4 <= hit3;
    end
    idx1 <= scan_idx;
    ld1 <= ball_loaded[scan_idx];
    idx2 <= idx1;
    dx2 <= abs_diff(obj_x, ball_q.geo.cx);
    dy2 <= abs_diff(obj_y, ball_q.geo.cy);
    dz2 <= abs_diff(obj_z, ball_q.geo.cz);
    r2 <= ball_q.geo.r;
    summ2 <= ball_q.summ;
    idx3 <= idx2;
    // squares only matter when every distance is below the radius
    near3 <= (dx2 < 33'(r2)) && (dy2 < 33'(r2)) && (dz2 < 33'(r2));
    sqx3 <= 62'(dx2[30:0]) * 62'(dx2[30:0]);
    sqy3 <= 62'(dy2[30:0]) * 62'(dy2[30:0]);
    sqz3 <= 62'(dz2[30:0]) * 62'(dz2[30:0]);
    rr3 <= 62'(r2) * 62'(r2);
    summ3 <= summ2;
    idx4 <= idx3;
    summ4 <= summ3;
  end

  // member append and summary update of a hit ball
  bmc_pkg::summ_t summ_upd;
  logic has_room;
  assign has_room = summ4.count < bmc_pkg::MEMB_LIMIT;
  always_comb begin
    summ_upd = summ4;
    if (has_room) summ_upd.count = summ4.count + 1'b1;
    else summ_upd.overflow = 1'b1;
    if (obj_p && summ4.p_count != bmc_pkg::P_MAX) summ_upd.p_count = summ4.p_count + 1'b1;
    summ_upd.interior = summ4.interior & obj_interior;
  end

  logic [bmc_pkg::RAD_W-1:0] eff_r;
  assign eff_r = (items.item.ball_radius > eps) ? items.item.ball_radius - eps : '0;

  logic is_load, is_read;
  assign is_load = accept && (items.item.kind == bmc_pkg::KIND_LOAD);
  assign is_read = accept && (items.item.kind == bmc_pkg::KIND_READ);

  always_comb begin
    ball_we = is_load || v4;
    ball_geo_we = is_load;
    ball_wa = v4 ? idx4 : items.item.ball_slot[bmc_pkg::BALL_AW-1:0];
    ball_wd.geo = '{cx: items.item.pos_x, cy: items.item.pos_y, cz: items.item.pos_z,
                    r: eff_r};
    ball_wd.summ = v4 ? summ_upd : bmc_pkg::SUMM_RESET;
    ball_re = is_read || (state == ST_SCAN);
    ball_ra = is_read ? items.item.ball_slot[bmc_pkg::BALL_AW-1:0] : scan_idx;

    store_we = v4 && has_room;
    store_wa = {idx4, summ4.count[bmc_pkg::MEMB_AW-1:0]};
    store_re = is_read;
    store_ra = {items.item.ball_slot[bmc_pkg::BALL_AW-1:0], items.item.member_slot};
  end

  logic scan_last;
  assign scan_last = (scan_idx == bmc_pkg::BALL_AW'(bmc_pkg::MAX_BALLS - 1));

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && items.item.kind == bmc_pkg::KIND_OBJECT) state_next = ST_SCAN;
        else if (is_read) state_next = ST_RDOUT;
      end
      ST_SCAN: begin
        if (scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!v1 && !v2 && !v3 && !v4) state_next = ST_IDLE;
      end
      ST_RDOUT: begin
        if (!results.valid || results.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // result from the registered memory outputs
  bmc_pkg::out_item_t rd_item;
  logic entry_ok;
  assign entry_ok = {1'b0, rd_mslot} < ball_q.summ.count;
  always_comb begin
    rd_item = '0;
    if (rd_loaded) begin
      rd_item.member_id = entry_ok ? store_q : '0;
      rd_item.entry_valid = entry_ok;
      rd_item.members_stored = ball_q.summ.count;
      rd_item.p_total = ball_q.summ.p_count;
      rd_item.qualifies = ball_q.summ.p_count > min_size;
      rd_item.all_interior = ball_q.summ.interior;
      rd_item.effective_radius = ball_q.geo.r;
      rd_item.list_overflow = ball_q.summ.overflow;
    end
  end

  assign rd_pending = (state == ST_RDOUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      eps <= '0;
      min_size <= '0;
      ball_loaded <= '0;
      scan_idx <= '0;
      results.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == bmc_pkg::REG_EPS) eps <= cfg.data[bmc_pkg::RAD_W-1:0];
        else if (cfg.index == bmc_pkg::REG_MIN_SIZE) min_size <= cfg.data[bmc_pkg::P_W-1:0];
      end
      if (is_load) ball_loaded[items.item.ball_slot[bmc_pkg::BALL_AW-1:0]] <= 1'b1;
      if (accept && items.item.kind == bmc_pkg::KIND_CLEAR) ball_loaded <= '0;
      if (state == ST_SCAN) scan_idx <= scan_idx + 1'b1;
      else scan_idx <= '0;
      if (rd_pending && (!results.valid || results.ready)) results.valid <= 1'b1;
      else if (results.ready) results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      obj_x <= items.item.pos_x;
      obj_y <= items.item.pos_y;
      obj_z <= items.item.pos_z;
      obj_id <= items.item.object_id;
      obj_interior <= items.item.object_interior;
      obj_p <= items.item.is_p_label;
      rd_loaded <= ball_loaded[items.item.ball_slot[bmc_pkg::BALL_AW-1:0]];
      rd_mslot <= items.item.member_slot;
    end
    if (rd_pending && (!results.valid || results.ready)) results.item <= rd_item;
  end

  `BMC_ASSERT_IMP(a_hit_loaded, clk, rst, v4, ball_loaded[idx4], "update of an unloaded ball")
  `BMC_ASSERT_IMP(a_pipe_idle, clk, rst, (state == ST_IDLE) || (state == ST_RDOUT), !v1 && !v2 && !v3 && !v4, "scan pipeline busy outside a scan")
  `BMC_ASSERT_NXT(a_clear, clk, rst, accept && items.item.kind == bmc_pkg::KIND_CLEAR, ball_loaded == '0, "clear left a ball loaded")

endmodule

@@ tb/sv/ball_membership_clusterer_tb.sv @@
// self-checking testbench for ball_membership_clusterer: directed and random item
// streams, a local predictor of ball membership, field checks of every read result
// depends on bmc_pkg, bmc_ifs and the ball_membership_clusterer rtl
module ball_membership_clusterer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 150;

  logic clk = 0;
  logic rst = 1;
  always #2 clk = ~clk;

  bmc_cfg_if cfg();
  bmc_in_if items();
  bmc_out_if results();

  ball_membership_clusterer dut (
    .clk(clk), .rst(rst), .cfg(cfg.sink), .items(items.sink),
    .results(results.source)
  );

  // ball state as the predictor sees it
  logic [bmc_pkg::RAD_W-1:0] eps_q = '0;
  logic [bmc_pkg::P_W-1:0] min_size_q = '0;
  longint ctr_x [bmc_pkg::MAX_BALLS];
  longint ctr_y [bmc_pkg::MAX_BALLS];
  longint ctr_z [bmc_pkg::MAX_BALLS];
  logic [bmc_pkg::RAD_W-1:0] eff_rad [bmc_pkg::MAX_BALLS];
  logic loaded [bmc_pkg::MAX_BALLS];
  logic [bmc_pkg::P_W-1:0] p_cnt [bmc_pkg::MAX_BALLS];
  logic [bmc_pkg::CNT_W-1:0] memb_cnt [bmc_pkg::MAX_BALLS];
  logic interior [bmc_pkg::MAX_BALLS];
  logic ovf [bmc_pkg::MAX_BALLS];
  logic [bmc_pkg::ID_W-1:0] memb_ids [bmc_pkg::MAX_BALLS][bmc_pkg::MAX_MEMBERS];

  bmc_pkg::in_item_t pending_items [$];
  bmc_pkg::out_item_t expected_reads [$];
  int errors = 0;
  int reads_checked = 0;
  int hits = 0;
  int overflow_reads = 0;
  int cycles = 0;
  bit quiet = 0;
  bit long_hold_req = 0;

  function automatic void queue_item(bmc_pkg::in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic void clear_balls();
    for (int b = 0; b < bmc_pkg::MAX_BALLS; b++) begin
      loaded[b] = 0;
      p_cnt[b] = '0;
      memb_cnt[b] = '0;
      interior[b] = 1;
      ovf[b] = 0;
    end
  endfunction

  function automatic bit ball_hit(int b, longint x, longint y, longint z);
    longint unsigned r, dx, dy, dz;
    r = eff_rad[b];
    dx = (x >= ctr_x[b]) ? x - ctr_x[b] : ctr_x[b] - x;
    dy = (y >= ctr_y[b]) ? y - ctr_y[b] : ctr_y[b] - y;
    dz = (z >= ctr_z[b]) ? z - ctr_z[b] : ctr_z[b] - z;
    if (dx >= r || dy >= r || dz >= r) return 0;
    return dx * dx + dy * dy + dz * dz < r * r;
  endfunction

  function automatic void predict_membership(bmc_pkg::in_item_t it);
    int s;
    bmc_pkg::out_item_t o;
    s = it.ball_slot;
    case (bmc_pkg::kind_t'(it.kind))
      bmc_pkg::KIND_LOAD: begin
        ctr_x[s] = $signed(it.pos_x);
        ctr_y[s] = $signed(it.pos_y);
        ctr_z[s] = $signed(it.pos_z);
        eff_rad[s] = (it.ball_radius > eps_q) ? it.ball_radius - eps_q : '0;
        loaded[s] = 1;
        p_cnt[s] = '0;
        memb_cnt[s] = '0;
        interior[s] = 1;
        ovf[s] = 0;
      end
      bmc_pkg::KIND_OBJECT: begin
        for (int b = 0; b < bmc_pkg::MAX_BALLS; b++) begin
          if (loaded[b] && ball_hit(b, $signed(it.pos_x), $signed(it.pos_y),
                                    $signed(it.pos_z))) begin
            hits++;
            if (memb_cnt[b] < bmc_pkg::MAX_MEMBERS) begin
              memb_ids[b][memb_cnt[b]] = it.object_id;
              memb_cnt[b]++;
            end else begin
              ovf[b] = 1;
            end
            if (it.is_p_label && p_cnt[b] != bmc_pkg::P_MAX) p_cnt[b]++;
            if (!it.object_interior) interior[b] = 0;
          end
        end
      end
      bmc_pkg::KIND_CLEAR: clear_balls();
      default: begin
        o = '0;
        if (loaded[s]) begin
          if (it.member_slot < memb_cnt[s]) begin
            o.member_id = memb_ids[s][it.member_slot];
            o.entry_valid = 1;
          end
          o.members_stored = memb_cnt[s];
          o.p_total = p_cnt[s];
          o.qualifies = p_cnt[s] > min_size_q;
          o.all_interior = interior[s];
          o.effective_radius = eff_rad[s];
          o.list_overflow = ovf[s];
          if (ovf[s]) overflow_reads++;
        end
        expected_reads = {expected_reads, o};
      end
    endcase
  endfunction

  // sender
  int send_gap = 0;
  always @(posedge clk) begin
    logic next_valid;
    if (rst) begin
      items.valid <= 0;
      items.item <= '0;
    end else begin
      next_valid = items.valid;
      if (items.valid && items.ready) predict_membership(items.item);
      if (!items.valid || items.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          next_valid = 0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 8);
          next_valid = 0;
        end else if (pending_items.size() > 0) begin
          items.item <= pending_items.pop_front();
          next_valid = 1;
        end else begin
          next_valid = 0;
        end
      end
      items.valid <= next_valid;
    end
  end

  // receiver
  int recv_stall = 0;
  int long_hold = 0;
  bit long_hold_done = 0;
  always @(posedge clk) begin
    bmc_pkg::out_item_t e, a;
    if (rst) begin
      results.ready <= 0;
    end else begin
      if (results.valid && results.ready) begin
        a = results.item;
        reads_checked++;
        if (expected_reads.size() == 0) begin
          errors++;
          $display("%0t: read result with none expected, actual %p", $time, a);
        end else begin
          e = expected_reads.pop_front();
          if (a.member_id !== e.member_id) begin
            errors++;
            $display("%0t: member_id expected %0d actual %0d", $time, e.member_id, a.member_id);
          end
          if (a.entry_valid !== e.entry_valid) begin
            errors++;
            $display("%0t: entry_valid expected %0d actual %0d", $time, e.entry_valid,
                     a.entry_valid);
          end
          if (a.members_stored !== e.members_stored) begin
            errors++;
            $display("%0t: members_stored expected %0d actual %0d", $time, e.members_stored,
                     a.members_stored);
          end
          if (a.p_total !== e.p_total) begin
            errors++;
            $display("%0t: p_total expected %0d actual %0d", $time, e.p_total, a.p_total);
          end
          if (a.qualifies !== e.qualifies) begin
            errors++;
            $display("%0t: qualifies expected %0d actual %0d", $time, e.qualifies, a.qualifies);
          end
          if (a.all_interior !== e.all_interior) begin
            errors++;
            $display("%0t: all_interior expected %0d actual %0d", $time, e.all_interior,
                     a.all_interior);
          end
          if (a.effective_radius !== e.effective_radius) begin
            errors++;
            $display("%0t: effective_radius expected %0d actual %0d", $time,
                     e.effective_radius, a.effective_radius);
          end
          if (a.list_overflow !== e.list_overflow) begin
            errors++;
            $display("%0t: list_overflow expected %0d actual %0d", $time, e.list_overflow,
                     a.list_overflow);
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1;
        long_hold = 600;
      end
      if (long_hold > 0) begin
        long_hold--;
        results.ready <= 0;
      end else if (recv_stall > 0) begin
        recv_stall--;
        results.ready <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        recv_stall = $urandom_range(0, 8);
        results.ready <= 0;
      end else begin
        results.ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic bmc_pkg::in_item_t mk(bmc_pkg::kind_t k, longint x, longint y,
                                           longint z, longint unsigned rad, int slot,
                                           int mslot);
    bmc_pkg::in_item_t it;
    it.kind = k;
    it.pos_x = x[31:0];
    it.pos_y = y[31:0];
    it.pos_z = z[31:0];
    it.ball_radius = rad[bmc_pkg::RAD_W-1:0];
    it.object_id = bmc_pkg::ID_W'($urandom);
    it.object_interior = 1'($urandom_range(0, 1));
    it.is_p_label = 1'($urandom_range(0, 1));
    it.ball_slot = 6'(slot);
    it.member_slot = 8'(mslot);
    return it;
  endfunction

  function automatic bmc_pkg::in_item_t mk_obj(longint x, longint y, longint z, bit intr,
                                               bit p);
    bmc_pkg::in_item_t it;
    it = mk(bmc_pkg::KIND_OBJECT, x, y, z, $urandom, $urandom, $urandom);
    it.object_interior = intr;
    it.is_p_label = p;
    return it;
  endfunction

  task automatic write_reg(bmc_pkg::reg_idx_t idx, logic [bmc_pkg::CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    if (idx == bmc_pkg::REG_EPS) eps_q = value[bmc_pkg::RAD_W-1:0];
    else min_size_q = value[bmc_pkg::P_W-1:0];
    cfg.valid <= 0;
  endtask

  // objects can leave the block busy with no result pending, so allow the scan time
  task automatic wait_idle();
    while (pending_items.size() > 0 || items.valid || expected_reads.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic longint near_coord(int spread);
    return longint'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  task automatic random_phase(int n_items, bit with_overflow);
    int live [$];
    int s, b, pick;
    longint unsigned rad;
    bmc_pkg::in_item_t it;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (live.size() == 0 || pick < 8) begin
        s = $urandom_range(0, bmc_pkg::MAX_BALLS - 1);
        rad = longint'(eps_q) + $urandom_range(0, 1 << 21);
        if (rad > 32'h7fffffff) rad = 32'h7fffffff;
        if ($urandom_range(0, 9) == 0) begin
          it = mk(bmc_pkg::KIND_LOAD, int'($urandom), int'($urandom), int'($urandom),
                  $urandom, s, 0);
        end else begin
          it = mk(bmc_pkg::KIND_LOAD, near_coord(1 << 21), near_coord(1 << 21),
                  near_coord(1 << 21), rad, s, 0);
        end
        queue_item(it);
        live = {live, s};
      end else if (pick < 55) begin
        b = live[$urandom_range(0, live.size() - 1)];
        if (loaded[b] || 1) begin
          it = mk(bmc_pkg::KIND_OBJECT, near_coord(1 << 21), near_coord(1 << 21),
                  near_coord(1 << 21), $urandom, $urandom, $urandom);
          queue_item(it);
        end
      end else if (pick < 85) begin
        s = live[$urandom_range(0, live.size() - 1)];
        it = mk(bmc_pkg::KIND_READ, int'($urandom), int'($urandom), int'($urandom),
                $urandom, s,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6));
        queue_item(it);
      end else if (pick < 88) begin
        queue_item(mk(bmc_pkg::KIND_CLEAR, int'($urandom), int'($urandom), int'($urandom),
                      $urandom, $urandom, $urandom));
        live.delete();
      end else begin
        // noise: anything the fields allow
        it = mk(bmc_pkg::kind_t'($urandom_range(0, 3)), int'($urandom), int'($urandom),
                int'($urandom), $urandom, $urandom, $urandom);
        queue_item(it);
      end
      if (with_overflow && i == n_items / 2) begin
        s = $urandom_range(0, bmc_pkg::MAX_BALLS - 1);
        queue_item(mk(bmc_pkg::KIND_LOAD, 64'sd5 <<< 30, -(64'sd3 <<< 30), 64'sd7 <<< 30,
                      longint'(eps_q) + 1000, s, 0));
        for (int k = 0; k < bmc_pkg::MAX_MEMBERS + 6; k++)
          queue_item(mk_obj(64'sd5 <<< 30, -(64'sd3 <<< 30), 64'sd7 <<< 30,
                            $urandom_range(0, 7) != 0, $urandom_range(0, 1)));
        queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, s, 255));
        queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, s, 0));
        live = {live, s};
      end
    end
  endtask

  initial begin
    longint unsigned big;
    clear_balls();
    cfg.valid = 0;
    cfg.index = '0;
    cfg.data = '0;
    items.valid = 0;
    items.item = '0;
    results.ready = 0;
    repeat (6) @(posedge clk);
    rst <= 0;
    big = 32'h7fffffff;

    write_reg(bmc_pkg::REG_EPS, 0);
    write_reg(bmc_pkg::REG_MIN_SIZE, 0);

    // directed: hits, exact-boundary misses, unfilled positions, extremes, reload, clear
    queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, 5, 0));
    queue_item(mk(bmc_pkg::KIND_LOAD, 0, 0, 0, 10 << 16, 0, 0));
    queue_item(mk_obj(3 << 16, 4 << 16, 0, 1, 1));
    queue_item(mk_obj(10 << 16, 0, 0, 1, 1));
    queue_item(mk_obj(6 << 16, -(8 << 16), 0, 1, 1));
    queue_item(mk_obj(1 << 16, 0, 0, 0, 0));
    pending_items[$].object_id = 0;
    queue_item(mk_obj(0, 0, -(9 << 16), 1, 1));
    pending_items[$].object_id = 31'h7fffffff;
    queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, 0, 0));
    queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, 0, 2));
    queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, 0, 3));
    queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, 0, 255));
    queue_item(mk(bmc_pkg::KIND_LOAD, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                  big, 63, 0));
    queue_item(mk_obj(64'sd2147483647, 64'sd2147483647, -64'sd2147483648, 0, 1));
    queue_item(mk_obj(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 1, 1));
    queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, 63, 0));
    queue_item(mk(bmc_pkg::KIND_LOAD, 0, 0, 0, 0, 1, 0));
    queue_item(mk_obj(0, 0, 0, 1, 1));
    queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, 1, 0));
    queue_item(mk(bmc_pkg::KIND_LOAD, 0, 0, 0, 2 << 16, 0, 0));
    queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, 0, 0));
    queue_item(mk(bmc_pkg::KIND_CLEAR, 0, 0, 0, 0, 0, 0));
    queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, 63, 0));
    wait_idle();

    random_phase(400, 1);
    wait_idle();

    write_reg(bmc_pkg::REG_EPS, 5 << 16);
    write_reg(bmc_pkg::REG_MIN_SIZE, 2);
    long_hold_req <= 1;
    queue_item(mk(bmc_pkg::KIND_LOAD, 0, 0, 0, 5 << 16, 2, 0));
    queue_item(mk_obj(0, 0, 0, 1, 1));
    queue_item(mk(bmc_pkg::KIND_READ, 0, 0, 0, 0, 2, 0));
    random_phase(400, 0);
    wait_idle();

    write_reg(bmc_pkg::REG_EPS, 32'h7fffffff);
    write_reg(bmc_pkg::REG_MIN_SIZE, 20'hfffff);
    random_phase(100, 0);
    wait_idle();

    write_reg(bmc_pkg::REG_EPS, $urandom_range(0, 1 << 18));
    write_reg(bmc_pkg::REG_MIN_SIZE, $urandom_range(0, 4));
    random_phase(260, 0);
    wait_idle();

    write_reg(bmc_pkg::REG_EPS, 0);
    write_reg(bmc_pkg::REG_MIN_SIZE, 1);
    quiet <= 1;
    random_phase(150, 0);
    wait_idle();

    $display("covered %0d read results, %0d ball hits, %0d reads of overflowed lists",
             reads_checked, hits, overflow_reads);
    $display("mismatches: %0d", errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/bmc_pkg.sv
src/bmc_ifs.sv
src/ball_membership_clusterer.sv
tb/sv/ball_membership_clusterer_tb.sv
